// File: design/assert_macros.svh
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every clock edge, quiet while reset is asserted.
`define LFA_ASSERT_RUN(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Check on every clock edge, reset included.
`define LFA_ASSERT_ALL(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// File: design/lfa_pkg.sv
// ----------------------------------------------------------------------------
// lfa_pkg
// Types, command codes and helpers shared by the identifier allocator.
// ----------------------------------------------------------------------------
package lfa_pkg;

    localparam int CMD_W     = 3;
    localparam int FIRST_W   = 10;
    localparam int END_W     = 11;
    localparam int RID_W     = 10;
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 16;
    localparam int WORD_W    = 32;
    localparam int OFF_W     = 5;

    localparam logic [CMD_W-1:0] CMD_ALLOC       = 3'd0;
    localparam logic [CMD_W-1:0] CMD_RELEASE     = 3'd1;
    localparam logic [CMD_W-1:0] CMD_MARK        = 3'd2;
    localparam logic [CMD_W-1:0] CMD_MARK_RANGE  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_ALLOC_RANGE = 3'd4;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_START,
        ST_EVAL,
        ST_OUT
    } lfa_state_t;

    typedef struct packed {
        logic clr_step;
        logic capture;
        logic start;
        logic rd_en;
        logic eval_en;
        logic out_load;
    } lfa_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic imm_done;
        logic eval_done;
        logic out_busy;
    } lfa_status_t;

    // Index of the single set bit of a one-hot word.
    function automatic logic [OFF_W-1:0] onehot_index(input logic [WORD_W-1:0] oh);
        logic [OFF_W-1:0] idx;
        idx = '0;
        for (int k = 0; k < WORD_W; k++) begin
            if (oh[k]) begin
                idx = idx | OFF_W'(k);
            end
        end
        return idx;
    endfunction

endpackage

// File: design/lfa_ram.sv
// ----------------------------------------------------------------------------
// lfa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lfa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                                   aclk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: design/lfa_ctrl.sv
// ----------------------------------------------------------------------------
// lfa_ctrl
// Sequencer: clearing pass, request intake, word scan and result hand-off.
// ----------------------------------------------------------------------------
module lfa_ctrl import lfa_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  lfa_status_t status,
    output lfa_cmd_t    cmd
);

    lfa_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: begin
                if (status.clr_last) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (s_tvalid) state_next = ST_START;
            end
            ST_START: begin
                state_next = status.imm_done ? ST_OUT : ST_EVAL;
            end
            ST_EVAL: begin
                if (status.eval_done) state_next = ST_OUT;
            end
            ST_OUT: begin
                if (!status.out_busy) state_next = ST_IDLE;
            end
            default: state_next = ST_CLEAR;
        endcase
    end

    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        case (state_reg)
            ST_CLEAR: cmd.clr_step = 1'b1;
            ST_IDLE: begin
                s_tready    = 1'b1;
                cmd.capture = s_tvalid;
            end
            ST_START: begin
                cmd.start = 1'b1;
                cmd.rd_en = 1'b1;
            end
            ST_EVAL: begin
                cmd.eval_en = 1'b1;
                cmd.rd_en   = 1'b1;
            end
            ST_OUT: cmd.out_load = !status.out_busy;
            default: cmd = '0;
        endcase
    end

endmodule

// File: design/lfa_dp.sv
// ----------------------------------------------------------------------------
// lfa_dp
// Datapath: request registers, free-map RAM, per-word claim logic, output.
// ----------------------------------------------------------------------------
module lfa_dp import lfa_pkg::*; #(
    parameter int ID_COUNT = 1024
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [S_TDATA_W-1:0] s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,
    input  lfa_cmd_t             cmd,
    output lfa_status_t          status
);

    localparam int WORDS = (ID_COUNT + WORD_W - 1) / WORD_W;
    localparam int WAW   = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int BW    = ($clog2(ID_COUNT + 1) > END_W) ? $clog2(ID_COUNT + 1) : END_W;
    localparam logic [BW-1:0] IDC = BW'(ID_COUNT);

    // Request fields
    logic [CMD_W-1:0]   in_cmd;
    logic [BW-1:0]      in_first, in_end, lo_c, endc, hi_c;

    logic [CMD_W-1:0]   cmd_reg;
    logic [BW-1:0]      lo_reg, hi_reg;
    logic               over_reg, empty_reg;
    logic [WAW-1:0]     w_reg, wlast_reg, clr_reg;
    logic [RID_W-1:0]   rid_reg;
    logic               ok_reg;
    logic               m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;

    // Scan signals
    logic [WORD_W-1:0]  rd_word, wr_word, mask, cand, iso, blk, blk_iso;
    logic [OFF_W-1:0]   lo_off, hi_off;
    logic [BW-1:0]      hm1, rid_full;
    logic               last;
    logic               imm_done, imm_ok;
    logic               ev_done, ev_ok;
    logic [RID_W-1:0]   ev_rid;

    logic               ram_we;
    logic [WAW-1:0]     ram_waddr, ram_raddr;
    logic [WORD_W-1:0]  ram_wdata;

    assign in_cmd   = s_tdata[CMD_W-1:0];
    assign in_first = BW'(s_tdata[CMD_W +: FIRST_W]);
    assign in_end   = BW'(s_tdata[CMD_W+FIRST_W +: END_W]);

    always_comb begin
        lo_c = (in_cmd == CMD_ALLOC) ? BW'(1) : in_first;
        if (in_cmd == CMD_ALLOC) begin
            endc = IDC;
        end else if (in_cmd inside {CMD_RELEASE, CMD_MARK}) begin
            endc = in_first + BW'(1);
        end else begin
            endc = in_end;
        end
        hi_c = (endc > IDC) ? IDC : endc;
    end

    // Outcomes known before any word is read
    always_comb begin
        imm_done = 1'b0;
        imm_ok   = 1'b0;
        case (cmd_reg)
            CMD_ALLOC, CMD_ALLOC_RANGE: imm_done = (lo_reg >= hi_reg);
            CMD_RELEASE: imm_done = (lo_reg == '0) || (lo_reg >= hi_reg);
            CMD_MARK, CMD_MARK_RANGE: begin
                if (empty_reg) begin
                    imm_done = 1'b1;
                    imm_ok   = 1'b1;
                end else begin
                    imm_done = (lo_reg >= hi_reg);
                end
            end
            default: imm_done = 1'b1;
        endcase
    end

    // One map word per cycle
    assign hm1    = hi_reg - BW'(1);
    assign last   = (w_reg == wlast_reg);
    assign lo_off = (w_reg == WAW'(lo_reg >> OFF_W)) ? lo_reg[OFF_W-1:0] : '0;
    assign hi_off = last ? hm1[OFF_W-1:0] : OFF_W'(WORD_W - 1);
    assign mask   = ({WORD_W{1'b1}} >> (OFF_W'(WORD_W - 1) - hi_off))
                  & ({WORD_W{1'b1}} << lo_off);
    assign cand    = rd_word & mask;
    assign iso     = cand & (~cand + WORD_W'(1));
    assign blk     = mask & ~rd_word;
    assign blk_iso = blk & (~blk + WORD_W'(1));
    assign rid_full = BW'({w_reg, onehot_index(iso)});

    always_comb begin
        wr_word = rd_word;
        ev_done = 1'b1;
        ev_ok   = 1'b0;
        ev_rid  = '0;
        if (cmd_reg inside {CMD_ALLOC, CMD_ALLOC_RANGE}) begin
            if (cand != '0) begin
                wr_word = rd_word & ~iso;
                ev_ok   = 1'b1;
                ev_rid  = rid_full[RID_W-1:0];
            end else begin
                ev_done = last;
            end
        end else if (cmd_reg == CMD_RELEASE) begin
            if (cand == '0) begin
                wr_word = rd_word | mask;
                ev_ok   = 1'b1;
            end
        end else begin
            // claim in rising order, stop at the first used identifier
            if (blk == '0) begin
                wr_word = rd_word & ~mask;
                ev_done = last;
                ev_ok   = !over_reg;
            end else begin
                wr_word = rd_word & ~(mask & (blk_iso - WORD_W'(1)));
            end
        end
    end

    // Free map storage
    always_comb begin
        ram_we    = cmd.clr_step || cmd.eval_en;
        ram_waddr = cmd.clr_step ? clr_reg : w_reg;
        if (cmd.clr_step) begin
            ram_wdata = (clr_reg == '0) ? ~WORD_W'(1) : {WORD_W{1'b1}};
        end else begin
            ram_wdata = wr_word;
        end
        ram_raddr = (cmd.eval_en && !ev_done) ? w_reg + WAW'(1) : w_reg;
    end

    lfa_ram #(
        .WIDTH(WORD_W),
        .DEPTH(WORDS)
    ) u_map (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (cmd.rd_en),
        .raddr (ram_raddr),
        .rdata (rd_word)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cmd.clr_step) clr_reg <= clr_reg + WAW'(1);
            if (cmd.out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            cmd_reg   <= in_cmd;
            lo_reg    <= lo_c;
            hi_reg    <= hi_c;
            over_reg  <= (endc > IDC);
            empty_reg <= (endc <= lo_c);
            w_reg     <= WAW'(lo_c >> OFF_W);
            wlast_reg <= WAW'((hi_c - BW'(1)) >> OFF_W);
        end
        if (cmd.start && imm_done) begin
            ok_reg  <= imm_ok;
            rid_reg <= '0;
        end
        if (cmd.eval_en) begin
            if (ev_done) begin
                ok_reg  <= ev_ok;
                rid_reg <= ev_rid;
            end else begin
                w_reg <= w_reg + WAW'(1);
            end
        end
        if (cmd.out_load) begin
            m_tdata_reg <= {(M_TDATA_W-RID_W-1)'(0), ok_reg, rid_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    assign status.clr_last  = (clr_reg == WAW'(WORDS - 1));
    assign status.imm_done  = imm_done;
    assign status.eval_done = ev_done;
    assign status.out_busy  = m_tvalid_reg && !m_tready;

endmodule

// File: design/lowest_free_id_allocator.sv
// Sequence: an accepted request passes ST_START (first map read), then,
//   unless its outcome is known at once, ST_EVAL (32-identifier map words
//   scanned) and ST_OUT, which raises m_tvalid; the result waits for m_tready.
// Throughput: one request at a time, limited by the one-word-per-cycle read
//   of the free-map RAM. Reset: synchronous, active low; afterwards a clearing
//   pass writes all ceil(ID_COUNT/32) map words before s_tready rises.
// ----------------------------------------------------------------------------
// lowest_free_id_allocator
// Free-map identifier allocator: hands out the lowest free identifier and
// claims or releases single identifiers and ranges on request.
// ----------------------------------------------------------------------------
module lowest_free_id_allocator import lfa_pkg::*; #(
    parameter int ID_COUNT = 1024
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // Request channel
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // tdata: command[2:0], first_id[12:3], end_id[23:13]
    input  logic [S_TDATA_W-1:0] s_tdata,
    // Result channel
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // tdata: result_id[9:0], ok[10], zero pad[15:11]
    output logic [M_TDATA_W-1:0] m_tdata
);

    // Commands from the sequencer, status back from the datapath
    lfa_cmd_t    cmd;
    lfa_status_t status;

    // Sequencer: clear the map, take a request, scan words, hold the result
    lfa_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // Datapath: free map in RAM, one 32-bit word examined and written per cycle
    lfa_dp #(
        .ID_COUNT(ID_COUNT)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cmd      (cmd),
        .status   (status)
    );

endmodule

// File: design/lfa_checker.sv
// ----------------------------------------------------------------------------
// lfa_checker
// Port-level checks for the identifier allocator, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lfa_checker import lfa_pkg::*; (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic [S_TDATA_W-1:0] s_tdata,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    `LFA_ASSERT_RUN(a_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "result dropped or changed while stalled")
    `LFA_ASSERT_RUN(a_pad, m_tvalid |-> m_tdata[M_TDATA_W-1:RID_W+1] == '0, "pad bits set")
    `LFA_ASSERT_RUN(a_fail_zero, m_tvalid && !m_tdata[RID_W] |-> m_tdata[RID_W-1:0] == '0, "failed request returned an identifier")
    `LFA_ASSERT_ALL(a_clear, !aresetn |=> !s_tready, "request taken before clearing pass")

endmodule

bind lowest_free_id_allocator lfa_checker u_lfa_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
